FILE: design/tsdf_pkg.sv
// Package for the text stream display filter.
// Holds character codes, register indexes, the BCD counter and queue entry types.
// No dependencies.
package tsdf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int COUNT_DIGITS      = 6;
  localparam int CFG_INDEX_W       = 3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'd11;
  localparam logic [7:0] CTRL_LAST = 8'd31;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CTRL_OFS  = 8'd64;
  localparam logic [3:0] BCD_NINE  = 4'd9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } mode_t;

  typedef logic [COUNT_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t       digits;
    logic       number;
    logic       dollar;
    logic       caret;
    logic [7:0] ch;
  } cmd_t;

  localparam bcd_t BCD_ONE = bcd_t'(1);

endpackage

FILE: design/tsdf_chan_if.sv
// Channel interfaces of the text stream display filter: input, result, config.
// Depends on tsdf_pkg for widths.
interface tsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;
  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

interface tsdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tsdf_cfg_if;
  import tsdf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/tsdf_front.sv
// Front part: holds mode registers and per-file state, accepts and classifies bytes.
// Pushes one expansion command per kept byte. Depends on tsdf_pkg, tsdf_chan_if.
module tsdf_front (
  input  logic              clk,
  input  logic              rst_n,
  tsdf_in_if.sink           in_ch,
  tsdf_cfg_if.sink          cfg_ch,
  input  logic              q_full,
  output logic              q_push,
  output tsdf_pkg::cmd_t    q_cmd
);
  import tsdf_pkg::*;

  mode_t      mode_r, mode_nxt;
  bcd_t       cnt_r, cnt_nxt, cnt_e, cnt_inc;
  logic       als_r, als_nxt, als_e;
  logic [7:0] prev_r, prev_nxt, prev_e;
  logic [7:0] prev2_r, prev2_nxt, prev2_e;
  logic       seen_r, seen_nxt, seen_e;
  logic       accept, drop, number, caret;
  logic [7:0] c, c_tab, c_out;
  logic       all_nine;
  logic [COUNT_DIGITS:0] carry;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && !q_full;
  assign c            = in_ch.in_byte;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_ch.valid) begin
      case (cfg_reg_e'(cfg_ch.index))
        REG_NUMBER_NONBLANK:  mode_nxt.number_nonblank  = cfg_ch.data;
        REG_NUMBER_ALL:       mode_nxt.number_all       = cfg_ch.data;
        REG_SQUEEZE_BLANK:    mode_nxt.squeeze_blank    = cfg_ch.data;
        REG_SHOW_ENDS:        mode_nxt.show_ends        = cfg_ch.data;
        REG_SHOW_TABS:        mode_nxt.show_tabs        = cfg_ch.data;
        REG_SHOW_NONPRINTING: mode_nxt.show_nonprinting = cfg_ch.data;
        default: ;
      endcase
    end
  end

  // restore per-file state on a file start
  assign cnt_e   = in_ch.file_start ? BCD_ONE : cnt_r;
  assign als_e   = in_ch.file_start ? 1'b1 : als_r;
  assign prev_e  = in_ch.file_start ? CH_NL : prev_r;
  assign prev2_e = in_ch.file_start ? CH_NL : prev2_r;
  assign seen_e  = in_ch.file_start ? 1'b0 : seen_r;

  always_comb begin
    carry[0] = 1'b1;
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      carry[k+1] = carry[k] && (cnt_e[k] == BCD_NINE);
      if (!carry[k])
        cnt_inc[k] = cnt_e[k];
      else if (cnt_e[k] == BCD_NINE)
        cnt_inc[k] = 4'd0;
      else
        cnt_inc[k] = cnt_e[k] + 4'd1;
    end
    all_nine = carry[COUNT_DIGITS];
  end

  always_comb begin
    drop = mode_r.squeeze_blank && (prev_e == CH_NL) && (prev2_e == CH_NL)
           && (c == CH_NL) && seen_e;
    number = !drop && als_e &&
             ((mode_r.number_nonblank && (c != CH_NL)) ||
              (mode_r.number_all && !mode_r.number_nonblank));
    c_tab = (mode_r.show_tabs && (c == CH_TAB)) ? CH_I : c;
    caret = mode_r.show_tabs && (c == CH_TAB);
    c_out = c_tab;
    if (mode_r.show_nonprinting) begin
      if ((c_tab < CH_TAB) || ((c_tab >= CH_VT) && (c_tab <= CTRL_LAST))) begin
        caret = 1'b1;
        c_out = c_tab + CTRL_OFS;
      end else if (c_tab == CH_DEL) begin
        caret = 1'b1;
        c_out = c_tab - CTRL_OFS;
      end
    end
  end

  assign q_push        = accept && !drop;
  assign q_cmd.digits  = cnt_e;
  assign q_cmd.number  = number;
  assign q_cmd.dollar  = mode_r.show_ends && (c == CH_NL);
  assign q_cmd.caret   = caret;
  assign q_cmd.ch      = c_out;

  always_comb begin
    cnt_nxt   = cnt_r;
    als_nxt   = als_r;
    prev_nxt  = prev_r;
    prev2_nxt = prev2_r;
    seen_nxt  = seen_r;
    if (accept) begin
      cnt_nxt   = (number && !all_nine) ? cnt_inc : cnt_e;
      als_nxt   = (c_out == CH_NL) ? 1'b1 : (number ? 1'b0 : als_e);
      prev2_nxt = prev_e;
      prev_nxt  = c_out;
      seen_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      cnt_r   <= BCD_ONE;
      als_r   <= 1'b1;
      prev_r  <= CH_NL;
      prev2_r <= CH_NL;
      seen_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      als_r   <= als_nxt;
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

FILE: design/tsdf_queue.sv
// Short command queue between front and back parts.
// Register-based FIFO of tsdf_pkg::cmd_t entries. Depends on tsdf_pkg.
module tsdf_queue #(
  parameter int DEPTH = tsdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tsdf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output tsdf_pkg::cmd_t head_cmd
);
  import tsdf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)
      count_nxt = count_r + 1'b1;
    else if (pop && !push)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/tsdf_back.sv
// Back part: expands each queued command into output bytes, one per cycle unless out_ch stalls.
// Drives the registered result channel. Depends on tsdf_pkg, tsdf_chan_if.
module tsdf_back #(
  parameter int NUMBER_DIGITS = tsdf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  tsdf_pkg::cmd_t head_cmd,
  output logic           pop,
  tsdf_out_if.source     out_ch
);
  import tsdf_pkg::*;

  localparam int SW = $clog2(NUMBER_DIGITS + 4);
  localparam logic [SW-1:0] S_TAB    = SW'(NUMBER_DIGITS);
  localparam logic [SW-1:0] S_DOLLAR = SW'(NUMBER_DIGITS + 1);
  localparam logic [SW-1:0] S_CARET  = SW'(NUMBER_DIGITS + 2);
  localparam logic [SW-1:0] S_CHAR   = SW'(NUMBER_DIGITS + 3);

  logic [SW-1:0] step_r, step_nxt, start_step, cur_step, next_step;
  logic          started_r, started_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          fire, is_last;
  logic [7:0]    sel_byte, digit_byte;
  logic [COUNT_DIGITS:0] upper_zero;
  logic [7:0]    dchar [COUNT_DIGITS];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  // blank leading zeros, keep the rightmost digit
  always_comb begin
    upper_zero[COUNT_DIGITS] = 1'b1;
    for (int k = COUNT_DIGITS - 1; k >= 0; k--)
      upper_zero[k] = upper_zero[k+1] && (head_cmd.digits[k] == 4'd0);
    for (int k = 0; k < COUNT_DIGITS; k++)
      dchar[k] = (upper_zero[k] && (k != 0)) ? CH_SPACE : (CH_ZERO + {4'd0, head_cmd.digits[k]});
  end

  always_comb begin
    digit_byte = CH_SPACE;
    for (int p = 0; p < NUMBER_DIGITS; p++) begin
      if ((cur_step == SW'(p)) && (NUMBER_DIGITS - 1 - p < COUNT_DIGITS))
        digit_byte = dchar[(NUMBER_DIGITS - 1 - p) % COUNT_DIGITS];
    end
  end

  always_comb begin
    if (head_cmd.number)
      start_step = '0;
    else if (head_cmd.dollar)
      start_step = S_DOLLAR;
    else if (head_cmd.caret)
      start_step = S_CARET;
    else
      start_step = S_CHAR;
  end

  assign cur_step = started_r ? step_r : start_step;
  assign is_last  = (cur_step == S_CHAR);

  always_comb begin
    if (cur_step < S_TAB) begin
      sel_byte  = digit_byte;
      next_step = cur_step + 1'b1;
    end else if (cur_step == S_TAB) begin
      sel_byte  = CH_TAB;
      next_step = head_cmd.dollar ? S_DOLLAR : (head_cmd.caret ? S_CARET : S_CHAR);
    end else if (cur_step == S_DOLLAR) begin
      sel_byte  = CH_DOLLAR;
      next_step = head_cmd.caret ? S_CARET : S_CHAR;
    end else if (cur_step == S_CARET) begin
      sel_byte  = CH_CARET;
      next_step = S_CHAR;
    end else begin
      sel_byte  = head_cmd.ch;
      next_step = S_CHAR;
    end
  end

  assign fire = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = fire && is_last;

  always_comb begin
    step_nxt      = step_r;
    started_nxt   = started_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (fire) begin
      step_nxt      = next_step;
      started_nxt   = !is_last;
      out_byte_nxt  = sel_byte;
      out_last_nxt  = is_last;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    step_r     <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/text_stream_display_filter.sv
// Top level of the text stream display filter.
// Depends on tsdf_pkg, tsdf_chan_if, tsdf_front, tsdf_queue, tsdf_back.
//
// Usage:
//   in_ch  : one raw text byte per transfer, with file_start on the first
//            byte of each file to restore line count, line start and history.
//   out_ch : displayed bytes, one per transfer; last_of_run marks the final
//            byte caused by one input byte. Squeezed newlines cause none.
//   cfg_ch : writes one mode register per transfer (index 0..5, bit 0 of
//            data); always ready. Write only while the block is idle.
// The first output byte of an input goes through the command queue and the
//   output register before it is presented. The output stage sends one
//   output byte per cycle while out_ch is ready; a plain byte expands to one
//   output byte and a byte with a line number to NUMBER_DIGITS + 2 or more,
//   so the output stage sets the sustained rate.
// A QUEUE_DEPTH entry command queue sits between the input classifier and
//   the output expander; input stalls only when it is full.
// Reset (synchronous, rst_n low) clears all modes, sets the line count to
//   one and empties the queue and the output register.
// A stalled receiver holds out_ch steady; expansion and input resume when
//   out_ch.ready returns.
module text_stream_display_filter #(
  parameter int NUMBER_DIGITS = tsdf_pkg::NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = tsdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tsdf_in_if.sink     in_ch,
  tsdf_out_if.source  out_ch,
  tsdf_cfg_if.sink    cfg_ch
);
  import tsdf_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  tsdf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  tsdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  tsdf_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: dv/tsdf_display_checker.sv
`timescale 1ns / 1ps
// Checker for the text stream display filter. It mirrors the mode registers, predicts
// the displayed bytes for every input transfer and compares them with each output transfer.
// Depends on tsdf_pkg and the channel interfaces in tsdf_chan_if.
module tsdf_display_checker (
  input  logic clk,
  input  logic rst_n,
  tsdf_in_if   in_ch,
  tsdf_out_if  out_ch,
  tsdf_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count
);
  import tsdf_pkg::*;

  localparam int          DIGITS       = NUMBER_DIGITS_DEF;
  localparam logic [19:0] LINE_MAX     = 20'd999999;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } glyph_t;

  glyph_t      expected_glyphs[$];
  mode_t       mode;
  logic [19:0] line_no;
  logic        at_start;
  logic [7:0]  prev_ch;
  logic [7:0]  prev2_ch;
  logic        seen_byte;
  int          errors;
  int          checked;

  function automatic void restart_file();
    line_no   = 20'd1;
    at_start  = 1'b1;
    prev_ch   = CH_NL;
    prev2_ch  = CH_NL;
    seen_byte = 1'b0;
  endfunction

  function automatic void push_glyph(logic [7:0] ch);
    glyph_t g;
    g.ch   = ch;
    g.last = 1'b0;
    expected_glyphs.push_back(g);
  endfunction

  function automatic void render_byte(logic [7:0] raw, logic first);
    logic [7:0]  c;
    logic        drop;
    logic [19:0] v;
    logic [7:0]  digit_ch[DIGITS];
    int          base;
    int          k;
    glyph_t      g;
    c = raw;
    base = expected_glyphs.size();
    if (first) restart_file();
    drop = mode.squeeze_blank && prev_ch == CH_NL && prev2_ch == CH_NL
           && c == CH_NL && seen_byte;
    if (!drop && at_start && ((mode.number_nonblank && c != CH_NL)
                              || (mode.number_all && !mode.number_nonblank))) begin
      v = line_no;
      for (k = DIGITS - 1; k >= 0; k--) begin
        digit_ch[k] = (v == 0 && k != DIGITS - 1) ? CH_SPACE : CH_ZERO + 8'(v % 10);
        v = v / 10;
      end
      for (k = 0; k < DIGITS; k++) push_glyph(digit_ch[k]);
      push_glyph(CH_TAB);
      if (line_no < LINE_MAX) line_no = line_no + 20'd1;
      at_start = 1'b0;
    end
    if (!drop && mode.show_ends && c == CH_NL) push_glyph(CH_DOLLAR);
    if (!drop && mode.show_tabs && c == CH_TAB) begin
      push_glyph(CH_CARET);
      c = CH_I;
    end
    if (!drop && mode.show_nonprinting) begin
      if (c < CH_TAB || (c >= CH_VT && c <= CTRL_LAST)) begin
        push_glyph(CH_CARET);
        c = c + CTRL_OFS;
      end else if (c == CH_DEL) begin
        push_glyph(CH_CARET);
        c = c - CTRL_OFS;
      end
    end
    prev2_ch  = prev_ch;
    prev_ch   = c;
    seen_byte = 1'b1;
    if (c == CH_NL) at_start = 1'b1;
    if (!drop) push_glyph(c);
    if (expected_glyphs.size() > base) begin
      g = expected_glyphs.pop_back();
      g.last = 1'b1;
      expected_glyphs.push_back(g);
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (!rst_n) begin
      mode = '0;
      restart_file();
      expected_glyphs.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_e'(cfg_ch.index))
          REG_NUMBER_NONBLANK:  mode.number_nonblank  = cfg_ch.data;
          REG_NUMBER_ALL:       mode.number_all       = cfg_ch.data;
          REG_SQUEEZE_BLANK:    mode.squeeze_blank    = cfg_ch.data;
          REG_SHOW_ENDS:        mode.show_ends        = cfg_ch.data;
          REG_SHOW_TABS:        mode.show_tabs        = cfg_ch.data;
          REG_SHOW_NONPRINTING: mode.show_nonprinting = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_glyphs.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] unexpected output: byte %h last %b", $time,
                     out_ch.out_byte, out_ch.last_of_run);
        end else begin
          want = expected_glyphs.pop_front();
          checked++;
          if (out_ch.out_byte !== want.ch || out_ch.last_of_run !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("[%0t] mismatch: expected byte %h last %b, got byte %h last %b",
                       $time, want.ch, want.last, out_ch.out_byte, out_ch.last_of_run);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) render_byte(in_ch.in_byte, in_ch.file_start);
    end
    fail_count    <= errors;
    pending_count <= expected_glyphs.size();
    checked_count <= checked;
  end

endmodule

FILE: dv/tb_text_stream_display_filter.sv
`timescale 1ns / 1ps
// Testbench top for the text stream display filter. It drives directed and random text
// through the block under changing mode settings and reports the verdict.
// Depends on tsdf_pkg, tsdf_chan_if, text_stream_display_filter and tsdf_display_checker.
module tb_text_stream_display_filter;
  import tsdf_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 42;
  localparam int MAX_GAP       = 10;
  localparam int NUM_SETTINGS  = 8;
  localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  logic steady;
  int   fail_count;
  int   pending_count;
  int   checked_count;
  int   items_sent;

  tsdf_in_if  in_ch ();
  tsdf_out_if out_ch ();
  tsdf_cfg_if cfg_ch ();

  text_stream_display_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tsdf_display_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : sink_ready
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_byte(logic [7:0] b, logic first);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.file_start <= first;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic apply_modes(mode_t m);
    cfg_reg_e regs[6] = '{REG_NUMBER_NONBLANK, REG_NUMBER_ALL, REG_SQUEEZE_BLANK,
                          REG_SHOW_ENDS, REG_SHOW_TABS, REG_SHOW_NONPRINTING};
    logic [CFG_INDEX_W-1:0] idx;
    logic d;
    for (int k = 0; k <= 6; k++) begin
      if (k < 6) begin
        idx = regs[k];
        case (regs[k])
          REG_NUMBER_NONBLANK:  d = m.number_nonblank;
          REG_NUMBER_ALL:       d = m.number_all;
          REG_SQUEEZE_BLANK:    d = m.squeeze_blank;
          REG_SHOW_ENDS:        d = m.show_ends;
          REG_SHOW_TABS:        d = m.show_tabs;
          default:              d = m.show_nonprinting;
        endcase
      end else begin
        idx = $urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO;
        d   = 1'b1;
      end
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= d;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CH_NL;
    else if (r < 38) return CH_TAB;
    else if (r < 48) return 8'($urandom_range(0, 31));
    else if (r < 53) return CH_DEL;
    else if (r < 63) return 8'($urandom_range(128, 255));
    else return 8'($urandom_range(32, 126));
  endfunction

  initial begin : stimulus
    mode_t      settings[NUM_SETTINGS];
    logic [8:0] script[22];
    settings = '{
      mode_t'(6'b000000), mode_t'(6'b111111), mode_t'(6'b010000), mode_t'(6'b011100),
      mode_t'(6'b100011), mode_t'(6'b001011), mode_t'(6'($urandom)),
      mode_t'(6'($urandom))
    };
    script = '{
      {1'b1, CH_NL}, {1'b0, CH_NL}, {1'b0, 8'h41}, {1'b0, CH_TAB},
      {1'b0, 8'h00}, {1'b0, CTRL_LAST}, {1'b0, CH_DEL}, {1'b0, 8'h80},
      {1'b0, 8'hFF}, {1'b0, CH_VT}, {1'b0, 8'h08}, {1'b0, 8'h7E},
      {1'b0, CH_NL}, {1'b0, CH_NL}, {1'b0, CH_NL}, {1'b0, CH_NL},
      {1'b0, CH_SPACE}, {1'b1, 8'h42}, {1'b0, 8'h1B}, {1'b0, CH_NL},
      {1'b1, CH_TAB}, {1'b0, CH_NL}
    };
    items_sent = 0;
    steady     = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= 8'h00;
    in_ch.file_start <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_NUMBER_NONBLANK;
    cfg_ch.data      <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_modes(mode_t'(6'b111111));
    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);
    in_ch.valid <= 1'b0;
    drain();

    foreach (settings[p]) begin
      steady = (p % 3 == 2);
      apply_modes(settings[p]);
      repeat (PHASE_ITEMS) send_byte(pick_byte(), $urandom_range(0, 24) == 0);
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("Run summary: %0d input bytes over %0d mode settings plus a directed pass,",
             items_sent, NUM_SETTINGS);
    $display("  %0d displayed bytes compared, %0d still outstanding, %0d mismatches",
             checked_count, pending_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tsdf_pkg.sv
design/tsdf_chan_if.sv
design/tsdf_front.sv
design/tsdf_queue.sv
design/tsdf_back.sv
design/text_stream_display_filter.sv
dv/tsdf_display_checker.sv
dv/tb_text_stream_display_filter.sv
